@@ sv/fifo_page_replacement_assert.svh @@
// Assertion macros shared by the checker of the FIFO page-replacement block.
`ifndef FIFO_PAGE_REPLACEMENT_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpr assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpr assertion failed in the next cycle");

`endif

@@ sv/fpr_pkg.sv @@
// Package with the constants and word types of the FIFO page-replacement block.
package fpr_pkg;

    localparam int MAX_FRAMES = 32;
    localparam int PAGE_BITS  = 12;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TOTAL_W    = 16;
    localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = CNT_W'(4);

    typedef struct packed {
        logic                 restart;
        logic [PAGE_BITS-1:0] page;
    } fpr_in_t;

    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     frame;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [TOTAL_W-1:0]   fault_count;
        logic [TOTAL_W-1:0]   access_count;
    } fpr_out_t;

endpackage

@@ sv/fpr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/fifo_page_replacement.sv @@
// Top level of the FIFO page-replacement frame store.
//
// A reference is taken when start is high and busy is low; busy then stays high while one
// comparator walks the frame RAM, one frame per cycle through the registered read port. A hit
// ends the walk at the matching frame, a fault after the last frame in use. The result is
// shown for exactly one cycle with done high and cannot be held off by the receiver; the next
// reference may be taken in that same cycle. frame_count is written through the cfg channel
// while the block is idle.
module fifo_page_replacement
    import fpr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fpr_in_t          req,
    output logic             done,
    output fpr_out_t         rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cfg_reg, cfg_next;
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]     victim_reg, victim_next;
    logic [TOTAL_W-1:0]   fault_reg, fault_next;
    logic [TOTAL_W-1:0]   access_reg, access_next;
    logic                 done_reg, done_next;
    logic                 pend_reg, pend_next;

    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [IDX_W-1:0]     vslot_reg, vslot_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 hit_reg, hit_next;
    logic [PAGE_BITS-1:0] evict_page_reg, evict_page_next;
    fpr_out_t             rsp_reg, rsp_next;

    logic [CNT_W-1:0]     n_frames;
    logic                 accept;
    logic [IDX_W-1:0]     victim_eff;
    logic                 match;
    logic                 last;
    logic                 ev_valid;
    logic                 ram_we;
    logic [PAGE_BITS-1:0] ram_rdata;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy && !start;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            n_frames = CNT_W'(1);
        end
        else if (cfg_reg > CNT_W'(MAX_FRAMES))
        begin
            n_frames = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_frames = cfg_reg;
        end
    end

    assign victim_eff = req.restart ? '0 : victim_reg;
    assign match      = pend_reg && valid_reg[pend_idx_reg] && (ram_rdata == page_reg);
    assign last       = pend_reg && ({1'b0, pend_idx_reg} == n_frames - CNT_W'(1));
    assign ev_valid   = valid_reg[vslot_reg];
    assign ram_we     = (state_reg == ST_FINISH) && !hit_reg;

    fpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vslot_reg),
        .wdata (page_reg),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        valid_next      = valid_reg;
        victim_next     = victim_reg;
        fault_next      = fault_reg;
        access_next     = access_reg;
        done_next       = 1'b0;
        pend_next       = 1'b0;
        rd_idx_next     = rd_idx_reg;
        pend_idx_next   = pend_idx_reg;
        page_next       = page_reg;
        vslot_next      = vslot_reg;
        slot_next       = slot_reg;
        hit_next        = hit_reg;
        evict_page_next = evict_page_reg;
        rsp_next        = rsp_reg;

        if (cfg_valid && cfg_ready)
        begin
            cfg_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    page_next   = req.page;
                    rd_idx_next = '0;
                    vslot_next  = ({1'b0, victim_eff} >= n_frames) ? '0 : victim_eff;
                    if (req.restart)
                    begin
                        valid_next  = '0;
                        victim_next = '0;
                        fault_next  = '0;
                        access_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg < n_frames)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                if (pend_reg && (pend_idx_reg == vslot_reg))
                begin
                    evict_page_next = ram_rdata;
                end
                priority if (match)
                begin
                    hit_next   = 1'b1;
                    slot_next  = pend_idx_reg;
                    pend_next  = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (last)
                begin
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                rsp_next.hit           = hit_reg;
                rsp_next.frame         = hit_reg ? slot_reg : vslot_reg;
                rsp_next.evicted_valid = !hit_reg && ev_valid;
                rsp_next.evicted_page  = (!hit_reg && ev_valid) ? evict_page_reg : '0;
                if (!hit_reg)
                begin
                    valid_next[vslot_reg] = 1'b1;
                    victim_next = ({1'b0, vslot_reg} + CNT_W'(1) >= n_frames)
                                  ? '0 : vslot_reg + IDX_W'(1);
                    fault_next  = (fault_reg == '1) ? fault_reg : fault_reg + TOTAL_W'(1);
                end
                access_next           = (access_reg == '1) ? access_reg
                                                           : access_reg + TOTAL_W'(1);
                rsp_next.fault_count  = fault_next;
                rsp_next.access_count = access_next;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cfg_reg    <= FRAME_COUNT_RESET;
            valid_reg  <= '0;
            victim_reg <= '0;
            fault_reg  <= '0;
            access_reg <= '0;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cfg_reg    <= cfg_next;
            valid_reg  <= valid_next;
            victim_reg <= victim_next;
            fault_reg  <= fault_next;
            access_reg <= access_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        pend_idx_reg   <= pend_idx_next;
        page_reg       <= page_next;
        vslot_reg      <= vslot_next;
        slot_reg       <= slot_next;
        hit_reg        <= hit_next;
        evict_page_reg <= evict_page_next;
        rsp_reg        <= rsp_next;
    end

endmodule

@@ sv/fpr_checker.sv @@
// Port-level checker of the FIFO page-replacement block and its bind statement.
`include "fifo_page_replacement_assert.svh"

module fpr_checker
    import fpr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input fpr_in_t          req,
    input logic             done,
    input fpr_out_t         rsp,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CNT_W-1:0] cfg_data
);

    `FPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `FPR_ASSERT_NOW(a_done_idle, done, !busy)
    `FPR_ASSERT_NOW(a_hit_no_evict, done && rsp.hit, !rsp.evicted_valid && (rsp.evicted_page == '0))
    `FPR_ASSERT_NOW(a_fault_le_access, done, (rsp.fault_count <= rsp.access_count) && (rsp.access_count != '0))

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (.*);
